FILE: hw/rtl/hsd_pkg.sv
package hsd_pkg;

  localparam int CORDIC_STAGES = 24;

  // internal CORDIC datapath width (Q30 with headroom)
  localparam int CW = 34;

  // square root: radicand a<<30 with a <= 2^30, root up to 2^30
  localparam int SQ_RAD_W  = 61;
  localparam int SQ_ROOT_W = 31;

  localparam logic [23:0] RADIUS_RESET = 24'd6371000;

  // angles in units of 2^-17 degree
  localparam logic signed [26:0] DEG90_U17  = 27'sd11796480;
  localparam logic signed [26:0] DEG180_U17 = 27'sd23592960;

  localparam logic [63:0] ONE_Q30  = 64'd1 << 30;
  localparam logic [63:0] HALF_Q30 = 64'd1 << 29;

  typedef logic [63:0] u64_t;

  function automatic u64_t udiv(input u64_t n, input u64_t d);
    u64_t q;
    u64_t r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic u64_t isqrt64(input u64_t v_in);
    u64_t v;
    u64_t res;
    u64_t bt;
    v = v_in;
    res = '0;
    bt = 64'd1 << 62;
    while (bt > v) bt = bt >> 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v = v - (res + bt);
        res = (res >> 1) + bt;
      end else begin
        res = res >> 1;
      end
      bt = bt >> 2;
    end
    return res;
  endfunction

  // atan(1/m) in Q62
  function automatic u64_t atan_inv_q62(input u64_t m);
    u64_t p;
    u64_t sum;
    u64_t t;
    u64_t k;
    p = udiv(64'd1 << 62, m);
    sum = '0;
    k = '0;
    while (p != 0) begin
      t = udiv(p, 2 * k + 1);
      if (k[0]) sum = sum - t;
      else sum = sum + t;
      p = udiv(p, m * m);
      k = k + 1;
    end
    return sum;
  endfunction

  function automatic u64_t quarter_pi_q62();
    return 4 * atan_inv_q62(64'd5) - atan_inv_q62(64'd239);
  endfunction

  function automatic logic [31:0] atan_q30(input int i);
    u64_t sum;
    u64_t t;
    int k;
    sum = '0;
    k = 0;
    if (i == 0) begin
      sum = quarter_pi_q62();
    end else begin
      while (i * (2 * k + 1) <= 62) begin
        t = udiv((64'd1 << 62) >> (i * (2 * k + 1)), 64'(2 * k + 1));
        if (k[0]) sum = sum - t;
        else sum = sum + t;
        k = k + 1;
      end
    end
    t = (sum + (64'd1 << 31)) >> 32;
    return t[31:0];
  endfunction

  function automatic logic [31:0] gain_q30(input int n);
    u64_t prod;
    u64_t root;
    u64_t g;
    prod = 64'd1 << 60;
    for (int i = 0; i < n; i++) prod = prod + (prod >> (2 * i));
    root = isqrt64(prod);
    g = udiv((64'd1 << 60) + (root >> 1), root);
    return g[31:0];
  endfunction

  function automatic u64_t deg_to_rad_q40();
    return udiv(quarter_pi_q62() + 64'd45 * (64'd1 << 21), 64'd45 << 22);
  endfunction

  localparam u64_t D2R_Q40 = deg_to_rad_q40();
  localparam logic [17:0] D2R_HI = D2R_Q40[34:17];
  localparam logic [16:0] D2R_LO = D2R_Q40[16:0];

endpackage

FILE: hw/rtl/hsd_cordic_rot.sv
module hsd_cordic_rot #(
  parameter int STAGES = hsd_pkg::CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] ang,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);

  localparam int W = hsd_pkg::CW;
  localparam logic [31:0] GAIN_U = hsd_pkg::gain_q30(STAGES);
  localparam logic signed [W-1:0] GAIN = W'($signed({1'b0, GAIN_U}));

  logic signed [W-1:0] xs [STAGES];
  logic signed [W-1:0] ys [STAGES];
  logic signed [W-1:0] zs [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [31:0] ATAN_U = hsd_pkg::atan_q30(i);
    localparam logic signed [W-1:0] ATAN = W'($signed({1'b0, ATAN_U}));
    logic signed [W-1:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = GAIN;
      assign yi = '0;
      assign zi = W'(ang);
    end else begin : g_next
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[W-1]) begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          zs[i] <= zi - ATAN;
        end else begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          zs[i] <= zi + ATAN;
        end
      end
    end
  end

  assign cos_q30 = xs[STAGES-1][31:0];
  assign sin_q30 = ys[STAGES-1][31:0];

endmodule

FILE: hw/rtl/hsd_cordic_vec.sv
module hsd_cordic_vec #(
  parameter int STAGES = hsd_pkg::CORDIC_STAGES
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [hsd_pkg::SQ_ROOT_W-1:0]      x_in,
  input  logic [hsd_pkg::SQ_ROOT_W-1:0]      y_in,
  output logic signed [hsd_pkg::CW-1:0]      angle
);

  localparam int W = hsd_pkg::CW;

  logic signed [W-1:0] xs [STAGES];
  logic signed [W-1:0] ys [STAGES];
  logic signed [W-1:0] zs [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic [31:0] ATAN_U = hsd_pkg::atan_q30(i);
    localparam logic signed [W-1:0] ATAN = W'($signed({1'b0, ATAN_U}));
    logic signed [W-1:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = W'($signed({1'b0, x_in}));
      assign yi = W'($signed({1'b0, y_in}));
      assign zi = '0;
    end else begin : g_next
      assign xi = xs[i-1];
      assign yi = ys[i-1];
      assign zi = zs[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          xs[i] <= xi + (yi >>> i);
          ys[i] <= yi - (xi >>> i);
          zs[i] <= zi + ATAN;
        end else if (yi < 0) begin
          xs[i] <= xi - (yi >>> i);
          ys[i] <= yi + (xi >>> i);
          zs[i] <= zi - ATAN;
        end else begin
          xs[i] <= xi;
          ys[i] <= yi;
          zs[i] <= zi;
        end
      end
    end
  end

  assign angle = zs[STAGES-1];

endmodule

FILE: hw/rtl/hsd_sqrt.sv
module hsd_sqrt (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hsd_pkg::SQ_RAD_W-1:0]  rad,
  output logic [hsd_pkg::SQ_ROOT_W-1:0] root
);

  localparam int RW = hsd_pkg::SQ_RAD_W;
  localparam int QW = hsd_pkg::SQ_ROOT_W;

  logic [RW-1:0] rems  [QW];
  logic [QW-1:0] roots [QW];

  // one result bit per stage, MSB first
  for (genvar k = 0; k < QW; k++) begin : g_digit
    localparam int B = QW - 1 - k;
    logic [RW-1:0] ri;
    logic [QW-1:0] qi;
    logic [63:0]   trial;
    if (k == 0) begin : g_first
      assign ri = rad;
      assign qi = '0;
    end else begin : g_next
      assign ri = rems[k-1];
      assign qi = roots[k-1];
    end
    assign trial = (64'(qi) << (B + 1)) + (64'd1 << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (64'(ri) >= trial) begin
          rems[k]  <= ri - trial[RW-1:0];
          roots[k] <= qi | (QW'(1) << B);
        end else begin
          rems[k]  <= ri;
          roots[k] <= qi;
        end
      end
    end
  end

  assign root = roots[QW-1];

endmodule

FILE: hw/rtl/haversine_distance.sv
// Channel  Dir  Handshake              Beat
// in       in   in_valid / in_ready    first_lat, first_lon, second_lat, second_lon
// out      out  out_valid / out_ready  distance_m
// cfg      in   cfg_we                 cfg_wdata (sphere radius, meters)
//
// One beat per cycle in and out while the output is not stalled; the pipeline runs through
// the rotation CORDICs, the 31-stage square root and the vectoring CORDIC.
// rst clears the valid chain and loads the radius with its reset value.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module haversine_distance #(
  parameter int CORDIC_STAGES = hsd_pkg::CORDIC_STAGES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [23:0] first_lat,
  input  logic signed [24:0] first_lon,
  input  logic signed [23:0] second_lat,
  input  logic signed [24:0] second_lon,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [25:0]        distance_m,
  input  logic               cfg_we,
  input  logic [23:0]        cfg_wdata
);

  localparam int S   = CORDIC_STAGES;
  localparam int LAT = 44 + 2 * S;
  localparam int CW  = hsd_pkg::CW;
  localparam int QW  = hsd_pkg::SQ_ROOT_W;

  localparam logic signed [18:0] HI_S = $signed({1'b0, hsd_pkg::D2R_HI});
  localparam logic signed [17:0] LO_S = $signed({1'b0, hsd_pkg::D2R_LO});
  localparam logic signed [61:0] RAD_RND = 62'sd1 <<< 26;
  localparam logic signed [63:0] Q30_RND = $signed(hsd_pkg::HALF_Q30);
  localparam logic signed [32:0] ONE_S   = 33'sd1 <<< 30;

  function automatic logic signed [24:0] red180(input logic signed [26:0] d);
    logic signed [26:0] r;
    if (d >= hsd_pkg::DEG90_U17) r = d - hsd_pkg::DEG180_U17;
    else if (d < -hsd_pkg::DEG90_U17) r = d + hsd_pkg::DEG180_U17;
    else r = d;
    return r[24:0];
  endfunction

  // {negate, folded angle}
  function automatic logic [25:0] fold(input logic signed [26:0] v);
    logic signed [26:0] r;
    logic               n;
    n = 1'b1;
    if (v > hsd_pkg::DEG90_U17) r = hsd_pkg::DEG180_U17 - v;
    else if (v < -hsd_pkg::DEG90_U17) r = -hsd_pkg::DEG180_U17 - v;
    else begin
      r = v;
      n = 1'b0;
    end
    return {n, r[24:0]};
  endfunction

  function automatic logic signed [31:0] rnd_q30(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = (p + Q30_RND) >>> 30;
    return t[31:0];
  endfunction

  logic            en;
  logic [LAT-1:0]  vld;
  logic [23:0]     radius;

  assign out_valid = vld[LAT-1];
  assign en        = !out_valid || out_ready;
  assign in_ready  = en && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      radius <= hsd_pkg::RADIUS_RESET;
    end else begin
      if (en) vld <= {vld[LAT-2:0], in_valid};
      if (cfg_we) radius <= cfg_wdata;
    end
  end

  // p0: differences, doubled latitudes (all in 2^-17 degree)
  logic signed [24:0] dlat_p0, l1_p0, l2_p0;
  logic signed [25:0] dlon_p0;

  always_ff @(posedge clk) begin
    if (en) begin
      dlat_p0 <= 25'(second_lat) - 25'(first_lat);
      dlon_p0 <= 26'(second_lon) - 26'(first_lon);
      l1_p0   <= {first_lat, 1'b0};
      l2_p0   <= {second_lat, 1'b0};
    end
  end

  // p1: range reduction
  logic signed [24:0] ang [4];
  logic               ng_p1;
  logic [25:0]        f1, f2;

  assign f1 = fold(27'(l1_p0));
  assign f2 = fold(27'(l2_p0));

  always_ff @(posedge clk) begin
    if (en) begin
      ang[0] <= red180(27'(dlat_p0));
      ang[1] <= red180(27'(dlon_p0));
      ang[2] <= f1[24:0];
      ang[3] <= f2[24:0];
      ng_p1  <= f1[25] ^ f2[25];
    end
  end

  // p2/p3: degrees to radians, split multiply
  logic signed [43:0] ph [4];
  logic signed [42:0] pl [4];
  logic signed [31:0] rad [4];
  logic signed [61:0] rsum [4];
  logic               ng_p2, ng_p3;

  for (genvar k = 0; k < 4; k++) begin : g_rad
    assign rsum[k] = (62'(ph[k]) <<< 17) + 62'(pl[k]) + RAD_RND;
    always_ff @(posedge clk) begin
      if (en) begin
        ph[k]  <= ang[k] * HI_S;
        pl[k]  <= ang[k] * LO_S;
        rad[k] <= rsum[k][58:27];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ng_p2 <= ng_p1;
      ng_p3 <= ng_p2;
    end
  end

  // rotation CORDICs
  logic signed [31:0] sin_dlat, sin_dlon, cos1, cos2;
  logic [S-1:0]       ng_d;

  always_ff @(posedge clk) begin
    if (en) ng_d <= {ng_d[S-2:0], ng_p3};
  end

  hsd_cordic_rot #(.STAGES(S)) u_rot_dlat (
    .clk(clk), .en(en), .ang(rad[0]), .cos_q30(), .sin_q30(sin_dlat)
  );
  hsd_cordic_rot #(.STAGES(S)) u_rot_dlon (
    .clk(clk), .en(en), .ang(rad[1]), .cos_q30(), .sin_q30(sin_dlon)
  );
  hsd_cordic_rot #(.STAGES(S)) u_rot_lat1 (
    .clk(clk), .en(en), .ang(rad[2]), .cos_q30(cos1), .sin_q30()
  );
  hsd_cordic_rot #(.STAGES(S)) u_rot_lat2 (
    .clk(clk), .en(en), .ang(rad[3]), .cos_q30(cos2), .sin_q30()
  );

  // q1..q6: form a
  logic signed [63:0] sql_q1, sqn_q1, cc_q1, m_q3;
  logic               ng_q1;
  logic signed [31:0] latsq_q2, lonsq_q2, cc_q2, latsq_q3, latsq_q4, mr_q4;
  logic signed [32:0] asum;
  logic [30:0]        a_q5, a_q6, am_q6;

  assign asum = 33'(latsq_q4) + 33'(mr_q4);

  always_ff @(posedge clk) begin
    if (en) begin
      sql_q1   <= sin_dlat * sin_dlat;
      sqn_q1   <= sin_dlon * sin_dlon;
      cc_q1    <= cos1 * cos2;
      ng_q1    <= ng_d[S-1];
      latsq_q2 <= rnd_q30(sql_q1);
      lonsq_q2 <= rnd_q30(sqn_q1);
      cc_q2    <= rnd_q30(ng_q1 ? -cc_q1 : cc_q1);
      m_q3     <= cc_q2 * lonsq_q2;
      latsq_q3 <= latsq_q2;
      mr_q4    <= rnd_q30(m_q3);
      latsq_q4 <= latsq_q3;
      if (asum < 0) a_q5 <= '0;
      else if (asum > ONE_S) a_q5 <= 31'(ONE_S);
      else a_q5 <= asum[30:0];
      a_q6     <= a_q5;
      am_q6    <= 31'(ONE_S) - a_q5;
    end
  end

  // roots and angle
  logic [QW-1:0]        ra, rb;
  logic signed [CW-1:0] z;

  hsd_sqrt u_sqrt_a (
    .clk(clk), .en(en), .rad({a_q6, 30'b0}), .root(ra)
  );
  hsd_sqrt u_sqrt_b (
    .clk(clk), .en(en), .rad({am_q6, 30'b0}), .root(rb)
  );

  hsd_cordic_vec #(.STAGES(S)) u_vec (
    .clk(clk), .en(en), .x_in(rb), .y_in(ra), .angle(z)
  );

  // r1..r3: scale by radius, round
  logic [31:0] c_r1;
  logic [55:0] prod_r2;
  logic [56:0] prnd;

  assign prnd = 57'(prod_r2) + 57'(hsd_pkg::HALF_Q30);

  always_ff @(posedge clk) begin
    if (en) begin
      c_r1       <= z[CW-1] ? '0 : {z[30:0], 1'b0};
      prod_r2    <= radius * c_r1;
      distance_m <= prnd[55:30];
    end
  end

endmodule

FILE: sim/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STAGES = hsd_pkg::CORDIC_STAGES;
  localparam int LATENCY = 44 + 2 * STAGES;
  localparam longint CYCLE_LIMIT = 1000000;
  localparam longint LAT90 = 5898240;
  localparam longint LON180 = 11796480;
  localparam longint U17_90 = 90 * 131072;
  localparam longint U17_180 = 180 * 131072;
  localparam longint U17_360 = 360 * 131072;
  localparam longint Q30_ONE = longint'(1) << 30;

  typedef struct {
    logic signed [23:0] lat1;
    logic signed [24:0] lon1;
    logic signed [23:0] lat2;
    logic signed [24:0] lon2;
  } point_pair_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [23:0] first_lat = '0;
  logic signed [24:0] first_lon = '0;
  logic signed [23:0] second_lat = '0;
  logic signed [24:0] second_lon = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [25:0] distance_m;
  logic cfg_we = 1'b0;
  logic [23:0] cfg_wdata = '0;

  point_pair_t pending_pairs[$];
  logic [25:0] expected_dist[$];
  logic [23:0] radius_m = hsd_pkg::RADIUS_RESET;
  longint atan_tab[STAGES];
  longint cordic_gain;
  longint deg2rad_q40;
  int send_gap = 0;
  int stall_left = 0;
  bit send_burst = 0;
  bit recv_burst = 0;
  int errors = 0;
  int checked = 0;
  int radius_settings = 0;
  longint cycles = 0;

  haversine_distance uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .first_lat(first_lat), .first_lon(first_lon),
    .second_lat(second_lat), .second_lon(second_lon),
    .out_valid(out_valid), .out_ready(out_ready), .distance_m(distance_m),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  function automatic longint unsigned int_sqrt(input longint unsigned v_in);
    longint unsigned v, root, b;
    v = v_in;
    root = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= root + b) begin
        v = v - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned arctan_recip_q62(input longint unsigned m);
    longint unsigned p, acc, term, k;
    p = (64'd1 << 62) / m;
    acc = 0;
    k = 0;
    while (p != 0) begin
      term = p / (2 * k + 1);
      if (k[0]) acc = acc - term;
      else acc = acc + term;
      p = p / (m * m);
      k++;
    end
    return acc;
  endfunction

  function automatic void derive_constants();
    longint unsigned qpi, acc, term, prod, root;
    qpi = 4 * arctan_recip_q62(5) - arctan_recip_q62(239);
    atan_tab[0] = longint'((qpi + (64'd1 << 31)) >> 32);
    for (int i = 1; i < STAGES; i++) begin
      acc = 0;
      for (int k = 0; i * (2 * k + 1) <= 62; k++) begin
        term = ((64'd1 << 62) >> (i * (2 * k + 1))) / (2 * k + 1);
        if (k % 2 == 1) acc = acc - term;
        else acc = acc + term;
      end
      atan_tab[i] = longint'((acc + (64'd1 << 31)) >> 32);
    end
    prod = 64'd1 << 60;
    for (int i = 0; i < STAGES; i++) prod = prod + (prod >> (2 * i));
    root = int_sqrt(prod);
    cordic_gain = longint'(((64'd1 << 60) + root / 2) / root);
    deg2rad_q40 = longint'((qpi + 64'd45 * (64'd1 << 21)) / (64'd45 << 22));
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b + (Q30_ONE >> 1)) >>> 30;
  endfunction

  function automatic longint to_radians(input longint v);
    return (v * deg2rad_q40 + (longint'(1) << 26)) >>> 27;
  endfunction

  function automatic void rotate(input longint ang, output longint c, output longint s);
    longint x, y, z, nx;
    x = cordic_gain;
    y = 0;
    z = ang;
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_tab[i];
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_tab[i];
      end
      x = nx;
    end
    c = x;
    s = y;
  endfunction

  function automatic longint vector_angle(input longint y_in, input longint x_in);
    longint x, y, z, nx;
    x = x_in;
    y = y_in;
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + atan_tab[i]; x = nx;
      end else if (y < 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - atan_tab[i]; x = nx;
      end
    end
    return z;
  endfunction

  function automatic longint half_sin_sq(input longint v);
    longint r, c, s;
    r = ((v + U17_90) % U17_180 + U17_180) % U17_180 - U17_90;
    rotate(to_radians(r), c, s);
    return qmul(s, s);
  endfunction

  function automatic longint lat_cos(input longint lat);
    longint v, c, s;
    bit flip;
    flip = 0;
    v = lat * 2;
    v = ((v + U17_180) % U17_360 + U17_360) % U17_360 - U17_180;
    if (v > U17_90) begin
      v = U17_180 - v; flip = 1;
    end else if (v < -U17_90) begin
      v = -U17_180 - v; flip = 1;
    end
    rotate(to_radians(v), c, s);
    return flip ? -c : c;
  endfunction

  function automatic logic [25:0] great_circle_m(input point_pair_t p, input logic [23:0] r);
    longint lat1, lon1, lat2, lon2, a, ra, rb, c;
    longint unsigned d;
    lat1 = p.lat1;
    lon1 = p.lon1;
    lat2 = p.lat2;
    lon2 = p.lon2;
    a = half_sin_sq(lat2 - lat1) +
        qmul(qmul(lat_cos(lat1), lat_cos(lat2)), half_sin_sq(lon2 - lon1));
    if (a < 0) a = 0;
    if (a > Q30_ONE) a = Q30_ONE;
    ra = longint'(int_sqrt(longint'(a) << 30));
    rb = longint'(int_sqrt(longint'(Q30_ONE - a) << 30));
    c = 2 * vector_angle(ra, rb);
    if (c < 0) c = 0;
    d = (longint'(r) * c + (longint'(1) << 29)) >> 30;
    return d[25:0];
  endfunction

  function automatic int draw_gap(input bit burst);
    int roll;
    if (burst) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint rand_lat();
    if ($urandom_range(0, 9) == 0) return longint'($signed(24'($urandom)));
    return longint'($urandom_range(0, 2 * LAT90)) - LAT90;
  endfunction

  function automatic longint rand_lon();
    if ($urandom_range(0, 9) == 0) return longint'($signed(25'($urandom)));
    return longint'($urandom_range(0, 2 * LON180)) - LON180;
  endfunction

  function automatic point_pair_t make_pair(input longint a, input longint b,
                                            input longint c, input longint d);
    point_pair_t p;
    p.lat1 = a[23:0];
    p.lon1 = b[24:0];
    p.lat2 = c[23:0];
    p.lon2 = d[24:0];
    return p;
  endfunction

  function automatic point_pair_t rand_pair();
    longint a, b;
    int kind;
    a = rand_lat();
    b = rand_lon();
    kind = $urandom_range(0, 9);
    if (kind < 2)
      return make_pair(a, b, a + $signed($urandom_range(0, 400)) - 200,
                       b + $signed($urandom_range(0, 400)) - 200);
    if (kind == 2)
      return make_pair(a, b, -a + $signed($urandom_range(0, 100)) - 50,
                       b + LON180 + $signed($urandom_range(0, 100)) - 50);
    if (kind == 3) return make_pair(a, b, a, b);
    return make_pair(a, b, rand_lat(), rand_lon());
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) pending_pairs.push_back(rand_pair());
  endtask

  // idle only once nothing is queued, offered or awaited for a full pipeline depth
  task automatic drain();
    int quiet;
    quiet = 0;
    while (quiet < LATENCY + 20) begin
      @(posedge clk);
      if (pending_pairs.size() != 0 || in_valid || expected_dist.size() != 0) quiet = 0;
      else quiet++;
    end
  endtask

  task automatic set_radius(input logic [23:0] r);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
    radius_m = r;
    radius_settings++;
  endtask

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    point_pair_t p;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_dist.push_back(great_circle_m(
          make_pair(first_lat, first_lon, second_lat, second_lon), radius_m));
      if (!in_valid || in_ready) begin
        if ($urandom_range(0, 199) == 0) send_burst <= ~send_burst;
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_pairs.size() != 0) begin
          p = pending_pairs.pop_front();
          first_lat <= p.lat1;
          first_lon <= p.lon1;
          second_lat <= p.lat2;
          second_lon <= p.lon2;
          in_valid <= 1'b1;
          send_gap <= draw_gap(send_burst);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic [25:0] want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_dist.size() == 0) begin
          $error("distance_m beat with nothing expected: %0d", distance_m);
          errors++;
        end else begin
          want = expected_dist.pop_front();
          checked++;
          if (distance_m !== want) begin
            $error("distance_m expected %0d actual %0d", want, distance_m);
            errors++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) recv_burst <= ~recv_burst;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left <= draw_gap(recv_burst);
      end
    end
  end

  initial begin
    derive_constants();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: reset radius, poles, antipodes, seam, extreme bit patterns
    pending_pairs.push_back(make_pair(0, 0, 0, 0));
    pending_pairs.push_back(make_pair(LAT90, 0, -LAT90, 0));
    pending_pairs.push_back(make_pair(0, 0, 0, LON180));
    pending_pairs.push_back(make_pair(0, -LON180, 0, LON180));
    pending_pairs.push_back(make_pair(LAT90, -LON180, LAT90, LON180));
    pending_pairs.push_back(make_pair(-LAT90, 123456, -LAT90, -654321));
    pending_pairs.push_back(make_pair(0, 0, 1, 1));
    pending_pairs.push_back(make_pair(-(1 << 23), -(1 << 24), (1 << 23) - 1, (1 << 24) - 1));
    pending_pairs.push_back(make_pair((1 << 23) - 1, (1 << 24) - 1, -(1 << 23), -(1 << 24)));
    pending_pairs.push_back(make_pair(-1, -1, -1, -1));
    pending_pairs.push_back(make_pair(45 * 65536, 45 * 65536, -45 * 65536, -135 * 65536));
    pending_pairs.push_back(make_pair(2949120, 100, -2949120, 100 + LON180));
    pending_pairs.push_back(make_pair(LAT90 - 1, 0, LAT90, LON180));
    queue_random(10);
    drain();

    set_radius(24'hFFFFFF);
    pending_pairs.push_back(make_pair(0, 0, 0, LON180));
    queue_random(300);
    drain();

    set_radius(24'd1);
    queue_random(250);
    drain();

    set_radius(24'd0);
    queue_random(60);
    drain();

    set_radius(24'($urandom_range(1, 24'hFFFFFF)));
    queue_random(300);
    drain();

    set_radius(hsd_pkg::RADIUS_RESET);
    queue_random(420);
    drain();

    $display("checked %0d distances over %0d radius settings (incl. 0, 1, max)",
             checked, radius_settings + 1);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: haversine_distance.f
hw/rtl/hsd_pkg.sv
hw/rtl/hsd_cordic_rot.sv
hw/rtl/hsd_cordic_vec.sv
hw/rtl/hsd_sqrt.sv
hw/rtl/haversine_distance.sv
sim/testbench.sv
